// ----- design/nps_pkg.sv -----
// nps_pkg: shared types and constants for the nearest point search block
// used by nps_sq_unit and nearest_point_search; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

    // fixed field widths of the interface
    localparam int SLOT_W    = 10;   // point_index
    localparam int CNT_W     = 11;   // point_count register
    localparam int IDX_OUT_W = 11;   // nearest_index
    localparam int DIST_W    = 50;   // nearest_dist_sq

    // square unit: magnitudes up to MUL_W bits are squared exactly
    localparam int MUL_W   = 25;
    localparam int WIDE_W  = 33;     // room for the largest coordinate difference
    localparam int SQ_W    = DIST_W + 1;
    localparam int ACC_W   = DIST_W + 2;

    localparam logic [DIST_W-1:0]    DIST_MAX = {DIST_W{1'b1}};
    localparam logic [SQ_W-1:0]      SQ_SAT   = {1'b1, {DIST_W{1'b0}}};
    localparam logic [IDX_OUT_W-1:0] NO_INDEX = {IDX_OUT_W{1'b1}};

    // input word kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X,
        ST_Y,
        ST_Z,
        ST_SUM,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- design/nps_sq_unit.sv -----
// nps_sq_unit: registered squared difference of two signed coordinates
// saturates at 2^50 when the difference exceeds 25 bits; uses nps_pkg
`timescale 1ns / 1ps
`default_nettype none

module nps_sq_unit #(
    parameter int COORD_BITS = 24
) (
    input  wire                           i_clk,
    input  wire signed [COORD_BITS-1:0]   i_a,
    input  wire signed [COORD_BITS-1:0]   i_b,
    output logic [nps_pkg::SQ_W-1:0]      o_sq
);
    import nps_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0]      diff;
    logic [DW-1:0]             mag;
    logic [WIDE_W-1:0]         mag_wide;
    logic                      sat;
    logic [2*MUL_W-1:0]        prod;
    logic [SQ_W-1:0]           r_sq;
    logic [SQ_W-1:0]           n_sq;

    always_comb begin
        diff     = {i_a[COORD_BITS-1], i_a} - {i_b[COORD_BITS-1], i_b};
        mag      = diff[DW-1] ? DW'(-diff) : DW'(diff);
        mag_wide = WIDE_W'(mag);
        sat      = |mag_wide[WIDE_W-1:MUL_W];
        prod     = mag_wide[MUL_W-1:0] * mag_wide[MUL_W-1:0];
        n_sq     = sat ? SQ_SAT : SQ_W'(prod);
    end

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ----- design/nearest_point_search.sv -----
// nearest_point_search: point table and linear nearest neighbor scan
// depends on nps_pkg and nps_sq_unit
`timescale 1ns / 1ps
`default_nettype none

// The block holds up to MAX_POINTS 3D points, each three signed COORD_BITS-bit
// coordinates (Q15.8 metres at 24 bits), in a single-port table memory. A load
// word (mode 0) writes one slot and gives no result; a slot at or
// above MAX_POINTS is dropped. A query word (mode 1) scans slots 0 to
// point_count-1 (point_count capped at MAX_POINTS) and returns the slot with the
// smallest squared distance, the lowest slot winning a tie, and that distance
// saturated at 2^50-1. An empty table answers found = 0, index -1, distance 0.
// Only slots that were loaded may be searched; the table has no reset value.
// One squaring unit is shared by the three axes, so each searched point passes
// through the steps x, y, z, and sum and compare. With a free output register the
// result word is loaded in the finish state and shows in the same cycle that the
// input opens for the next word. The input is stalled for the whole scan.
// Results sit in an output register, so a new word is taken while an earlier
// result is still waiting to be taken downstream. The user must write
// point_count through i_cfg_we / i_cfg_wdata only while the block is idle; the
// block itself does not enforce this.

module nearest_point_search #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration
    input  wire                               i_cfg_we,
    input  wire [nps_pkg::CNT_W-1:0]          i_cfg_wdata,
    // input words
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_mode,
    input  wire [nps_pkg::SLOT_W-1:0]         i_point_index,
    input  wire signed [COORD_BITS-1:0]       i_pos_x,
    input  wire signed [COORD_BITS-1:0]       i_pos_y,
    input  wire signed [COORD_BITS-1:0]       i_pos_z,
    // result words
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic                              o_found,
    output logic signed [nps_pkg::IDX_OUT_W-1:0] o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]        o_nearest_dist_sq
);
    import nps_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int ENTRY_W = 3 * COORD_BITS;

    // table memory, layout {z, y, x}
    logic [ENTRY_W-1:0] mem [MAX_POINTS];

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]      r_point_count;
    logic [ENTRY_W-1:0]    r_entry;
    logic [ADDR_W-1:0]     r_idx;
    logic [ADDR_W-1:0]     r_last;
    logic                  r_found;
    logic [ADDR_W-1:0]     r_best_idx;
    logic [DIST_W-1:0]     r_best_dist;
    logic [ACC_W-1:0]      r_acc;
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic signed [COORD_BITS-1:0] r_qz;

    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IDX_OUT_W-1:0]  r_out_index;
    logic [DIST_W-1:0]     r_out_dist;

    logic                  in_accept;
    logic                  load_accept;
    logic                  query_accept;
    logic [31:0]           slot_wide;
    logic                  slot_ok;
    logic [31:0]           cnt_lim;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  out_free;
    logic                  out_load;
    logic                  last_point;
    logic signed [COORD_BITS-1:0] sq_a;
    logic signed [COORD_BITS-1:0] sq_b;
    logic [SQ_W-1:0]       sq;
    logic [ACC_W-1:0]      sum;
    logic [DIST_W-1:0]     cand_dist;
    logic                  better;
    logic [31:0]           best_wide;

    // handshake
    assign o_in_stall   = (r_state != ST_IDLE);
    assign in_accept    = i_in_valid && !o_in_stall;
    assign load_accept  = in_accept && (i_mode == MODE_LOAD);
    assign query_accept = in_accept && (i_mode == MODE_QUERY);

    assign slot_wide = 32'(i_point_index);
    assign slot_ok   = slot_wide < 32'(MAX_POINTS);

    // searched count, capped at the table depth
    assign cnt_lim = (32'(r_point_count) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                           : 32'(r_point_count);

    assign last_point = (r_idx == r_last);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_FIN) && out_free;

    // first entry is read on accept, the next one during the compare cycle
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (query_accept && (r_point_count != '0)) begin
            rd_en = 1'b1;
        end else if ((r_state == ST_SUM) && !last_point) begin
            rd_en   = 1'b1;
            rd_addr = r_idx + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_accept && slot_ok) begin
            mem[slot_wide[ADDR_W-1:0]] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        if (rd_en) begin
            r_entry <= mem[rd_addr];
        end
    end

    // shared squaring unit, one axis per cycle
    always_comb begin
        unique case (r_state)
            ST_Y: begin
                sq_a = r_qy;
                sq_b = $signed(r_entry[2*COORD_BITS-1:COORD_BITS]);
            end
            ST_Z: begin
                sq_a = r_qz;
                sq_b = $signed(r_entry[3*COORD_BITS-1:2*COORD_BITS]);
            end
            default: begin
                sq_a = r_qx;
                sq_b = $signed(r_entry[COORD_BITS-1:0]);
            end
        endcase
    end

    nps_sq_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_sq (
        .i_clk (i_clk),
        .i_a   (sq_a),
        .i_b   (sq_b),
        .o_sq  (sq)
    );

    // final add, saturate, compare against the running best
    assign sum       = r_acc + ACC_W'(sq);
    assign cand_dist = (sum > ACC_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    assign better    = (r_idx == '0) || (cand_dist < r_best_dist);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (query_accept) begin
                    n_state = (r_point_count == '0) ? ST_FIN : ST_X;
                end
            end
            ST_X:   n_state = ST_Y;
            ST_Y:   n_state = ST_Z;
            ST_Z:   n_state = ST_SUM;
            ST_SUM: n_state = last_point ? ST_FIN : ST_X;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (query_accept) begin
            r_qx    <= i_pos_x;
            r_qy    <= i_pos_y;
            r_qz    <= i_pos_z;
            r_idx   <= '0;
            r_last  <= cnt_lim[ADDR_W-1:0] - ADDR_W'(1);
            r_found <= (r_point_count != '0);
        end
        unique case (r_state)
            ST_Y: r_acc <= ACC_W'(sq);
            ST_Z: r_acc <= sum;
            ST_SUM: begin
                if (better) begin
                    r_best_dist <= cand_dist;
                    r_best_idx  <= r_idx;
                end
                if (!last_point) begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // output register
    assign best_wide = 32'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= r_found;
            r_out_index <= r_found ? best_wide[IDX_OUT_W-1:0] : NO_INDEX;
            r_out_dist  <= r_found ? r_best_dist : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_out_found;
    assign o_nearest_index   = $signed(r_out_index);
    assign o_nearest_dist_sq = r_out_dist;

endmodule

`default_nettype wire

// ----- design/nps_checker.sv -----
// nps_checker: port-level checks on nearest_point_search, bound to the top level
// depends on nps_pkg
`timescale 1ns / 1ps
`default_nettype none

module nps_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  o_in_stall,
    input  wire                                  i_mode,
    input  wire                                  o_out_valid,
    input  wire                                  i_out_stall,
    input  wire                                  o_found,
    input  wire [nps_pkg::IDX_OUT_W-1:0]         o_nearest_index,
    input  wire [nps_pkg::DIST_W-1:0]            o_nearest_dist_sq
);
    import nps_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
            && $stable(o_nearest_index) && $stable(o_nearest_dist_sq))
        else $error("result word changed while stalled");

    // not found always reads as index -1 and distance zero
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_nearest_index == NO_INDEX
            && o_nearest_dist_sq == '0)
        else $error("empty result carries an index or distance");

    // a query keeps the input stalled in the cycle after it is taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode == MODE_QUERY |=> o_in_stall)
        else $error("input taken right after a query");

    // a load never produces a result word
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode == MODE_LOAD && !o_out_valid |=> !o_out_valid)
        else $error("result word after a load");

endmodule

bind nearest_point_search nps_checker u_nps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_mode            (i_mode),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_found           (o_found),
    .o_nearest_index   (o_nearest_index),
    .o_nearest_dist_sq (o_nearest_dist_sq)
);

`default_nettype wire

// ----- sim/nearest_point_search_tb.sv -----
// nearest_point_search_tb: self-checking bench for the nearest point search block
// drives load and query words, predicts or takes from a table every answer, checks each result word
// depends on nps_pkg and nearest_point_search
`timescale 1ns / 1ps

module nearest_point_search_tb;
    import nps_pkg::*;

    localparam int MAX_PTS     = 1024;
    localparam int CRD_W       = 24;
    localparam int HOLD_CYCLES = 600;          // long receiver hold-off
    localparam int LOAD_SETTLE = 4;            // lets the last loads settle
    localparam int END_WAIT    = 4 * MAX_PTS + 16;  // longest scan plus margin
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SUB_ITEMS   = 42;
    localparam longint DIST_CAP = (64'sd1 <<< DIST_W) - 1;

    // point_count per random sub-phase, four per idling mode
    localparam int COUNT_PLAN [12] = '{1, 12, 0, 64, 33, 2, 64, 5, 64, 7, 0, 20};

    localparam logic signed [CRD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [CRD_W-1:0] C_MIN = 24'sh800000;
    localparam logic signed [CRD_W-1:0] C_0   = 24'sd0;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] index;
        logic [DIST_W-1:0]    dist_sq;
    } t_nearest;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic                    mode;
        logic [SLOT_W-1:0]       slot;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
        bit                      has_want;
        t_nearest                want;
        logic [CNT_W-1:0]        cnt;
    } t_stim_row;

    localparam t_nearest NOT_FOUND = '{1'b0, NO_INDEX, {DIST_W{1'b0}}};
    localparam t_nearest NO_WANT   = '0;
    // corner to opposite corner: 3 * (2^24-1)^2
    localparam logic [DIST_W-1:0] FAR_SQ = 50'd844424829468675;

    localparam int DIR_ROWS = 22;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CNT_W-1:0]        i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_mode;
    logic [SLOT_W-1:0]       i_point_index;
    logic signed [CRD_W-1:0] i_pos_x;
    logic signed [CRD_W-1:0] i_pos_y;
    logic signed [CRD_W-1:0] i_pos_z;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_found;
    logic signed [IDX_OUT_W-1:0] o_nearest_index;
    logic [DIST_W-1:0]       o_nearest_dist_sq;

    nearest_point_search #(
        .MAX_POINTS (MAX_PTS),
        .COORD_BITS (CRD_W)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_point_index     (i_point_index),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_found           (o_found),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_dist_sq (o_nearest_dist_sq)
    );

    // shadow of the point table and of point_count
    logic signed [CRD_W-1:0] pt_x [MAX_PTS];
    logic signed [CRD_W-1:0] pt_y [MAX_PTS];
    logic signed [CRD_W-1:0] pt_z [MAX_PTS];
    bit                      loaded [MAX_PTS];
    logic [CNT_W-1:0]        point_count;

    t_nearest  nearest_q [$];      // answers still owed by the block
    t_stim_row dir_tab [DIR_ROWS];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;                  // bumped by the stimulus, served by the receiver
    int hold_seen;
    int hold_left;
    int cycle_cnt;
    int n_loads;
    int n_queries;
    int n_empty;
    int n_answers;
    int n_bad;
    int max_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers pending", cycle_cnt,
                     nearest_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int searched_slots();
        return (point_count > MAX_PTS) ? MAX_PTS : int'(point_count);
    endfunction

    // linear scan over the shadow table, lowest slot wins a tie
    function automatic t_nearest predict_nearest(input logic signed [CRD_W-1:0] qx,
                                                 input logic signed [CRD_W-1:0] qy,
                                                 input logic signed [CRD_W-1:0] qz);
        t_nearest res;
        longint   dx, dy, dz, d, best;
        int       n;
        n    = searched_slots();
        res  = NOT_FOUND;
        best = 0;
        for (int s = 0; s < n; s++) begin
            dx = longint'(qx) - longint'(pt_x[s]);
            dy = longint'(qy) - longint'(pt_y[s]);
            dz = longint'(qz) - longint'(pt_z[s]);
            d  = dx * dx + dy * dy + dz * dz;
            if (d > DIST_CAP)
                d = DIST_CAP;
            if (s == 0 || d < best) begin
                best      = d;
                res.index = IDX_OUT_W'(s);
            end
        end
        if (n > 0) begin
            res.found   = 1'b1;
            res.dist_sq = best[DIST_W-1:0];
        end
        return res;
    endfunction

    // result side: check accepted words, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        t_nearest want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_answers <= n_answers + 1;
            if (nearest_q.size() == 0) begin
                if (n_bad < 10)
                    $display("unexpected result word: found=%0d index=%0d dist=%0d",
                             o_found, o_nearest_index, o_nearest_dist_sq);
                n_bad <= n_bad + 1;
            end else begin
                want = nearest_q.pop_front();
                if (o_found !== want.found || o_nearest_index !== want.index ||
                    o_nearest_dist_sq !== want.dist_sq) begin
                    if (n_bad < 10)
                        $display({"mismatch: want found=%0d index=%0d dist=%0d, ",
                                  "got found=%0d index=%0d dist=%0d"},
                                 want.found, $signed(want.index), want.dist_sq,
                                 o_found, o_nearest_index, o_nearest_dist_sq);
                    n_bad <= n_bad + 1;
                end
            end
        end
        // long hold-off: stall for a fixed stretch so the block backs up
        if (hold_left == 0 && hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one word, return at the edge it was taken; valid is left high
    task automatic offer_word(input logic mode, input logic [SLOT_W-1:0] slot,
                              input logic signed [CRD_W-1:0] x,
                              input logic signed [CRD_W-1:0] y,
                              input logic signed [CRD_W-1:0] z,
                              input bit has_want, input t_nearest want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_point_index <= slot;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        do @(posedge i_clk); while (o_in_stall);
        if (mode == MODE_LOAD) begin
            pt_x[slot]   = x;
            pt_y[slot]   = y;
            pt_z[slot]   = z;
            loaded[slot] = 1'b1;
            n_loads++;
        end else begin
            want = has_want ? want : predict_nearest(x, y, z);
            if (!want.found)
                n_empty++;
            nearest_q = {nearest_q, want};
            n_queries++;
        end
    endtask

    // sender pause until every owed answer has come, then let loads settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [CRD_W-1:0] wide_coord();
        return CRD_W'($urandom);
    endfunction

    // points packed near the origin make near ties common
    function automatic logic signed [CRD_W-1:0] cluster_coord();
        return CRD_W'($urandom_range(4095)) - 24'sd2048;
    endfunction

    function automatic logic signed [CRD_W-1:0] jitter();
        if ($urandom_range(3) == 0)
            return C_0;
        return CRD_W'($urandom_range(511)) - 24'sd256;
    endfunction

    // every slot that the new count searches must hold a point first
    task automatic set_point_count(input logic [CNT_W-1:0] cnt);
        int lim;
        lim = (cnt > MAX_PTS) ? MAX_PTS : int'(cnt);
        for (int s = 0; s < lim; s++)
            if (!loaded[s])
                offer_word(MODE_LOAD, SLOT_W'(s), wide_coord(), cluster_coord(),
                           wide_coord(), 1'b0, NO_WANT);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        point_count = cnt;
        if (int'(cnt) > max_count)
            max_count = int'(cnt);
    endtask

    // mostly queries near stored points and loads into searched slots
    task automatic run_random(input int items);
        int                      n, r, k;
        logic [SLOT_W-1:0]       slot;
        logic signed [CRD_W-1:0] x, y, z;
        for (int i = 0; i < items; i++) begin
            if (i == items / 2)
                wait_idle();
            n    = searched_slots();
            r    = $urandom_range(99);
            slot = SLOT_W'($urandom);
            if (r < 60) begin
                if (n > 0 && r < 45) begin
                    k = $urandom_range(n - 1);
                    x = pt_x[k] + jitter();
                    y = pt_y[k] + jitter();
                    z = pt_z[k] + jitter();
                end else begin
                    x = wide_coord();
                    y = wide_coord();
                    z = wide_coord();
                end
                offer_word(MODE_QUERY, slot, x, y, z, 1'b0, NO_WANT);
            end else begin
                if (n > 0 && r < 90)
                    slot = SLOT_W'($urandom_range(n - 1));
                if (n > 0 && $urandom_range(3) == 0) begin
                    // exact copy of another point gives a tie
                    k = $urandom_range(n - 1);
                    x = pt_x[k];
                    y = pt_y[k];
                    z = pt_z[k];
                end else if ($urandom_range(1) == 0) begin
                    x = cluster_coord();
                    y = cluster_coord();
                    z = cluster_coord();
                end else begin
                    x = wide_coord();
                    y = wide_coord();
                    z = wide_coord();
                end
                offer_word(MODE_LOAD, slot, x, y, z, 1'b0, NO_WANT);
            end
        end
    endtask

    initial begin
        // directed rows: empty table, extreme corners, ties, top slot
        dir_tab = '{
            '{ROW_WORD, MODE_QUERY, 10'd0,   C_0,   C_0,   C_0,   1'b1, NOT_FOUND, 11'd0},
            '{ROW_WORD, MODE_QUERY, 10'h3FF, C_MAX, C_MIN, C_MAX, 1'b1, NOT_FOUND, 11'd0},
            '{ROW_WORD, MODE_LOAD,  10'd0,   C_MAX, C_MAX, C_MAX, 1'b0, NO_WANT,   11'd0},
            '{ROW_WORD, MODE_LOAD,  10'd1,   C_MIN, C_MIN, C_MIN, 1'b0, NO_WANT,   11'd0},
            '{ROW_CFG,  MODE_LOAD,  10'd0,   C_0,   C_0,   C_0,   1'b0, NO_WANT,   11'd1},
            '{ROW_WORD, MODE_QUERY, 10'd0,   C_MIN, C_MIN, C_MIN, 1'b1,
              '{1'b1, 11'd0, FAR_SQ}, 11'd0},
            '{ROW_WORD, MODE_QUERY, 10'd0,   C_MAX, C_MAX, C_MAX, 1'b1,
              '{1'b1, 11'd0, 50'd0}, 11'd0},
            '{ROW_CFG,  MODE_LOAD,  10'd0,   C_0,   C_0,   C_0,   1'b0, NO_WANT,   11'd2},
            '{ROW_WORD, MODE_QUERY, 10'd0,   C_MIN, C_MIN, C_MIN, 1'b1,
              '{1'b1, 11'd1, 50'd0}, 11'd0},
            '{ROW_WORD, MODE_LOAD,  10'd2,   24'sd100,  C_0, C_0, 1'b0, NO_WANT,   11'd0},
            '{ROW_WORD, MODE_LOAD,  10'd3,   -24'sd100, C_0, C_0, 1'b0, NO_WANT,   11'd0},
            '{ROW_CFG,  MODE_LOAD,  10'd0,   C_0,   C_0,   C_0,   1'b0, NO_WANT,   11'd4},
            '{ROW_WORD, MODE_QUERY, 10'd0,   C_0,   C_0,   C_0,   1'b1,
              '{1'b1, 11'd2, 50'd10000}, 11'd0},
            '{ROW_WORD, MODE_LOAD,  10'd4,   24'sd100,  C_0, C_0, 1'b0, NO_WANT,   11'd0},
            '{ROW_WORD, MODE_LOAD,  10'h3FF, C_0,   C_0,   24'sd1, 1'b0, NO_WANT,  11'd0},
            '{ROW_CFG,  MODE_LOAD,  10'd0,   C_0,   C_0,   C_0,   1'b0, NO_WANT,   11'd5},
            '{ROW_WORD, MODE_QUERY, 10'd0,   C_0,   C_0,   C_0,   1'b1,
              '{1'b1, 11'd2, 50'd10000}, 11'd0},
            '{ROW_WORD, MODE_QUERY, 10'd7,   -24'sd100, C_0, C_0, 1'b1,
              '{1'b1, 11'd3, 50'd0}, 11'd0},
            '{ROW_WORD, MODE_QUERY, 10'd0,   24'sd1, 24'sd2, 24'sd3, 1'b0, NO_WANT, 11'd0},
            '{ROW_WORD, MODE_QUERY, 10'd0,   -24'sd50, 24'sd37, -24'sd9, 1'b0, NO_WANT,
              11'd0},
            '{ROW_CFG,  MODE_LOAD,  10'd0,   C_0,   C_0,   C_0,   1'b0, NO_WANT,   11'd0},
            '{ROW_WORD, MODE_QUERY, 10'd0,   24'sd5, 24'sd5, 24'sd5, 1'b1, NOT_FOUND,
              11'd0}
        };

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_LOAD;
        i_point_index  <= '0;
        i_pos_x        <= '0;
        i_pos_y        <= '0;
        i_pos_z        <= '0;
        i_out_stall    <= 1'b0;
        point_count    = '0;
        hold_req       = 0;
        hold_seen      = 0;
        hold_left      = 0;
        cycle_cnt      = 0;
        n_loads        = 0;
        n_queries      = 0;
        n_empty        = 0;
        n_answers      = 0;
        n_bad          = 0;
        max_count      = 0;
        send_idle_pct  = 11;
        recv_stall_pct = 55;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].kind == ROW_CFG)
                set_point_count(dir_tab[r].cnt);
            else
                offer_word(dir_tab[r].mode, dir_tab[r].slot, dir_tab[r].x, dir_tab[r].y,
                           dir_tab[r].z, dir_tab[r].has_want, dir_tab[r].want);
        end

        // sender idles lightly, then receiver idles lightly, then no random idling but one long hold-off
        for (int m = 0; m < 3; m++) begin
            send_idle_pct  = (m == 0) ? 11 : (m == 1) ? 55 : 0;
            recv_stall_pct = (m == 0) ? 55 : (m == 1) ? 11 : 0;
            for (int p = 0; p < 4; p++) begin
                set_point_count(CNT_W'(COUNT_PLAN[m * 4 + p]));
                if (m == 2 && p == 0)
                    hold_req++;
                run_random(SUB_ITEMS);
            end
        end

        wait_idle();
        repeat (END_WAIT) @(posedge i_clk);

        $display("covered %0d loads and %0d queries (%0d on an empty table), %s%0d",
                 n_loads, n_queries, n_empty, "counts up to ", max_count);
        $display("%0d result words checked, %0d failures", n_answers, n_bad);
        if (n_bad == 0 && nearest_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
